// ----- hdl/rcma_pkg.sv -----
// Package for the RNS coefficient modular ALU: request and result types, command codes and modulus register indexes.
package rcma_pkg;

    localparam int COEFF_W   = 62;
    localparam int CMD_W     = 3;
    localparam int IDX_W     = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEG    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_MAC    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_TENSOR = 3'd5;

    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS_3 = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [IDX_W-1:0]   mod_sel;
        logic [COEFF_W-1:0] op_a;
        logic [COEFF_W-1:0] op_b;
        logic [COEFF_W-1:0] op_c;
        logic [COEFF_W-1:0] op_d;
    } in_item_t;

    typedef struct packed {
        logic [COEFF_W-1:0] res_0;
        logic [COEFF_W-1:0] res_1;
        logic [COEFF_W-1:0] res_2;
        logic               operand_error;
    } out_item_t;

endpackage

// ----- hdl/rns_coefficient_modular_alu.sv -----
// Top level of the RNS coefficient modular ALU: pipelined modular add/sub/neg/mul/mac/tensor.
//
// Usage:
//   Requests enter on in_valid/in_stall/in_data, results leave on
//   out_valid/out_stall/out_data, one result per request, in order.
//   Moduli are written on cfg_valid/cfg_ready/cfg_index/cfg_data while idle;
//   cfg_ready is always high, indexes at or beyond MOD_COUNT are ignored.
//   The pipeline has one input register, one stage per multiplier bit of
//   the double-and-add chain, which holds four modular products side by
//   side, and one output register.
//   Throughput is one request per cycle while the receiver does not stall.
//   Reset clears all valid bits and sets every modulus to 2.
//   When the receiver stalls, the output register holds; empty stages keep
//   filling, so requests are still taken until every stage is occupied.
//   in_stall depends combinationally on out_stall through the stage chain.
module rns_coefficient_modular_alu
    import rcma_pkg::*;
#(
    parameter int MOD_COUNT   = 4,
    parameter int COEFF_WIDTH = 62
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEFF_W-1:0]   cfg_data
);

    localparam int W = COEFF_WIDTH;

    typedef logic [W-1:0] word_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             bad;
        logic             err;
        word_t            q;
        word_t            a;
        word_t            b;
        word_t            c;
        word_t            d;
        word_t            simple;
        word_t            p0;
        word_t            p1;
        word_t            p2;
        word_t            p3;
    } stage_t;

    function automatic word_t add_mod(input word_t x, input word_t y, input word_t q);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, q})
            s = s - {1'b0, q};
        return s[W-1:0];
    endfunction

    // one double-and-add step of the bit-serial modular product
    function automatic word_t mstep(input word_t r, input word_t x, input word_t q,
                                    input logic bt);
        word_t t;
        t = add_mod(r, r, q);
        if (bt)
            t = add_mod(t, x, q);
        return t;
    endfunction

    word_t  mod_reg [MOD_COUNT];
    stage_t pipe_reg [0:W];
    logic   valid_reg [0:W];
    stage_t stage_next [1:W];
    logic   load [0:W+1];
    stage_t entry_next;

    out_item_t out_reg, out_next;
    logic      out_valid_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MOD_COUNT; i++)
                mod_reg[i] <= word_t'(2);
        end
        else if (cfg_valid)
        begin
            for (int i = 0; i < MOD_COUNT; i++)
                if (int'(cfg_index) == i)
                    mod_reg[i] <= cfg_data[W-1:0];
        end
    end

    // handshake chain: a stage loads when empty or when the next one loads
    assign load[W+1] = !out_valid_reg || !out_stall;
    generate
        for (genvar k = 0; k <= W; k++)
        begin : g_load
            assign load[k] = !valid_reg[k] || load[k+1];
        end
    endgenerate
    assign in_stall = !load[0];

    always_comb
    begin
        entry_next     = '0;
        entry_next.cmd = in_data.cmd;
        entry_next.bad = 1'b1;
        entry_next.a   = in_data.op_a[W-1:0];
        entry_next.b   = in_data.op_b[W-1:0];
        entry_next.c   = in_data.op_c[W-1:0];
        entry_next.d   = in_data.op_d[W-1:0];
        for (int i = 0; i < MOD_COUNT; i++)
        begin
            if (int'(in_data.mod_sel) == i)
            begin
                entry_next.q   = mod_reg[i];
                entry_next.bad = 1'b0;
            end
        end
    end

    generate
        for (genvar k = 0; k < W; k++)
        begin : g_step
            always_comb
            begin
                stage_t s;
                word_t  y0;
                s  = pipe_reg[k];
                y0 = (s.cmd == CMD_TENSOR) ? s.c : s.b;
                s.p0 = mstep(pipe_reg[k].p0, s.a, s.q, y0[W-1-k]);
                s.p1 = mstep(pipe_reg[k].p1, s.b, s.q, s.c[W-1-k]);
                s.p2 = mstep(pipe_reg[k].p2, s.a, s.q, s.d[W-1-k]);
                s.p3 = mstep(pipe_reg[k].p3, s.b, s.q, s.d[W-1-k]);
                if (k == 0)
                begin
                    s.p0 = mstep('0, s.a, s.q, y0[W-1]);
                    s.p1 = mstep('0, s.b, s.q, s.c[W-1]);
                    s.p2 = mstep('0, s.a, s.q, s.d[W-1]);
                    s.p3 = mstep('0, s.b, s.q, s.d[W-1]);
                    s.err = s.bad || (s.cmd > CMD_TENSOR) || (s.a >= s.q)
                          || ((s.cmd != CMD_NEG) && (s.b >= s.q))
                          || (((s.cmd == CMD_MAC) || (s.cmd == CMD_TENSOR)) && (s.c >= s.q))
                          || ((s.cmd == CMD_TENSOR) && (s.d >= s.q));
                    if (s.cmd == CMD_ADD)
                        s.simple = add_mod(s.a, s.b, s.q);
                    else if (s.cmd == CMD_SUB)
                        s.simple = (s.a >= s.b) ? (s.a - s.b) : (s.a + s.q - s.b);
                    else
                        s.simple = (s.a == '0) ? '0 : (s.q - s.a);
                end
                stage_next[k+1] = s;
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= W; k++)
                valid_reg[k] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load[0])
                valid_reg[0] <= in_valid;
            for (int k = 1; k <= W; k++)
                if (load[k])
                    valid_reg[k] <= valid_reg[k-1];
            if (load[W+1])
                out_valid_reg <= valid_reg[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
            pipe_reg[0] <= entry_next;
        for (int k = 1; k <= W; k++)
            if (load[k])
                pipe_reg[k] <= stage_next[k];
        if (load[W+1])
            out_reg <= out_next;
    end

    always_comb
    begin
        stage_t f;
        word_t  r0, r1, r2;
        f  = pipe_reg[W];
        r0 = '0;
        r1 = '0;
        r2 = '0;
        unique case (f.cmd)
            CMD_ADD, CMD_SUB, CMD_NEG: r0 = f.simple;
            CMD_MUL:                   r0 = f.p0;
            CMD_MAC:                   r0 = add_mod(f.c, f.p0, f.q);
            CMD_TENSOR:
            begin
                r0 = f.p0;
                r1 = add_mod(f.p1, f.p2, f.q);
                r2 = f.p3;
            end
            default:                   r0 = '0;
        endcase
        out_next = '0;
        out_next.operand_error = f.err;
        if (!f.err)
        begin
            out_next.res_0 = COEFF_W'(r0);
            out_next.res_1 = COEFF_W'(r1);
            out_next.res_2 = COEFF_W'(r2);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

// ----- hdl/rcma_checker.sv -----
// Port-level checker for the RNS coefficient modular ALU, with its bind.
module rcma_checker
    import rcma_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input out_item_t out_data
);

    // a stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.operand_error |->
            out_data.res_0 == '0 && out_data.res_1 == '0 && out_data.res_2 == '0)
        else $error("error result carries non-zero data");

    // only a stalled receiver can back up the pipe
    a_no_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !out_stall |-> !in_stall)
        else $error("input stalled with a free output");

endmodule

bind rns_coefficient_modular_alu rcma_checker u_rcma_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
